@@ rtl/core/gifd_pkg.sv @@
// Shared constants and codes of the GIF LZW pixel decoder.
`default_nettype none
package gifd_pkg;
   localparam int MAX_CODE_BITS = 12;
   localparam int TAB_AW        = 12;
   localparam int TAB_DEPTH     = 4096;
   localparam int STK_AW        = 12;
   localparam int STK_DEPTH     = 4096;

   // Result status codes
   localparam logic [2:0] ST_TAKEN = 3'd0;
   localparam logic [2:0] ST_BUSY  = 3'd1;
   localparam logic [2:0] ST_PIXEL = 3'd2;
   localparam logic [2:0] ST_NEED  = 3'd3;
   localparam logic [2:0] ST_ENDED = 3'd4;

   // Operations
   localparam logic OP_FEED = 1'b0;
   localparam logic OP_PULL = 1'b1;

   // Configuration register indexes
   localparam logic [2:0] REG_MIN_CODE_SIZE = 3'd0;
   localparam logic [2:0] REG_COLOR_BITS    = 3'd1;
   localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd2;
   localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd3;
   localparam logic [2:0] REG_INTERLACED    = 3'd4;
endpackage
`default_nettype wire

@@ rtl/core/gif_lzw_pixel_decoder_unit.sv @@
// GIF LZW pixel decoder: one sequencer around the string table and pixel stack memories.
// After reset the string table memory is cleared in one pass over its 4096 entries, during which
// no item is taken. One item is handled at a time. A pull that finds pixels on the stack passes
// through the decode, stack read and response states. Decoding a code passes through the decode
// and table read states plus a read and a write state for every entry of its string chain,
// since each step of the chain is a registered read of the table memory; a clear code, the
// end code and the literal after a clear are handled in the decode state alone. A feed decodes
// ready codes both before and after it merges its byte, a refused feed or a pull that finds no
// pixel first decodes what it can, and a feed after the end code goes straight to the response.
`default_nettype none
module gif_lzw_pixel_decoder_unit import gifd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_operation,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_pixel_index,
   output logic [15:0]      rsp_pixel_x,
   output logic [15:0]      rsp_pixel_y,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_DEC  = 3'd2;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_WR   = 3'd4;
   localparam logic [2:0] S_POPD = 3'd5;
   localparam logic [2:0] S_RSP  = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [TAB_AW-1:0] clr_ff, clr_in;
   logic        op_ff, op_in, phase_ff, phase_in;
   logic [7:0]  byte_ff, byte_in;
   logic [23:0] bb_ff, bb_in;
   logic [4:0]  bc_ff, bc_in;
   logic [12:0] sc_ff, sc_in;
   logic [3:0]  ccw_ff, ccw_in;
   logic [12:0] nfc_ff, nfc_in;
   logic [11:0] prev_ff, prev_in, cur_ff, cur_in, incode_ff, incode_in;
   logic [7:0]  lfc_ff, lfc_in;
   logic        exp_ff, exp_in, fin_ff, fin_in;
   logic [15:0] col_ff, col_in, row_ff, row_in;
   logic [1:0]  pass_ff, pass_in;
   logic [3:0]  mcs_ff, mcs_in, cbits_ff, cbits_in;
   logic [15:0] width_ff, width_in, height_ff, height_in;
   logic        ilace_ff, ilace_in;
   logic [2:0]  res_st_ff, res_st_in;
   logic [7:0]  res_pix_ff, res_pix_in;
   logic [15:0] res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_st_ff, rsp_st_in;
   logic [7:0]  rsp_pix_ff, rsp_pix_in;
   logic [15:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   // String table: prefix in the upper twelve bits, suffix in the lower eight.
   logic [19:0] tab_mem [TAB_DEPTH];
   logic [19:0] tab_rd_ff;
   logic        tab_we;
   logic [TAB_AW-1:0] tab_wa, tab_ra;
   logic [19:0] tab_wd;
   logic [7:0]  stk_mem [STK_DEPTH];
   logic [7:0]  stk_rd_ff;
   logic        stk_we;
   logic [STK_AW-1:0] stk_wa, stk_ra;
   logic [7:0]  stk_wd;

   logic [3:0]  em;
   logic [3:0]  eff_cb;
   logic [8:0]  clear_code;
   logic [7:0]  cmask;
   logic [11:0] code_mask, code;
   logic [12:0] nfc_next;
   logic [15:0] col_next;
   logic [16:0] row_step;

   always_comb begin
      em = mcs_ff;
      if (mcs_ff < 4'd2) em = 4'd2;
      if (mcs_ff > 4'd8) em = 4'd8;
      eff_cb = cbits_ff;
      if (cbits_ff < 4'd1) eff_cb = 4'd1;
      if (cbits_ff > 4'd8) eff_cb = 4'd8;
      clear_code = 9'(9'd1 << em);
      cmask      = 8'((9'd1 << eff_cb) - 9'd1);
      code_mask  = 12'((13'd1 << ccw_ff) - 13'd1);
      code       = bb_ff[11:0] & code_mask;
      nfc_next   = nfc_ff + 13'd1;
   end

   always_comb begin
      state_in = state_ff;  clr_in = clr_ff;  op_in = op_ff;  phase_in = phase_ff;
      byte_in = byte_ff;  bb_in = bb_ff;  bc_in = bc_ff;  sc_in = sc_ff;
      ccw_in = ccw_ff;  nfc_in = nfc_ff;  prev_in = prev_ff;  cur_in = cur_ff;
      incode_in = incode_ff;  lfc_in = lfc_ff;  exp_in = exp_ff;  fin_in = fin_ff;
      col_in = col_ff;  row_in = row_ff;  pass_in = pass_ff;
      mcs_in = mcs_ff;  cbits_in = cbits_ff;  width_in = width_ff;
      height_in = height_ff;  ilace_in = ilace_ff;
      res_st_in = res_st_ff;  res_pix_in = res_pix_ff;
      res_x_in = res_x_ff;  res_y_in = res_y_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_st_in = rsp_st_ff;  rsp_pix_in = rsp_pix_ff;
      rsp_x_in = rsp_x_ff;  rsp_y_in = rsp_y_ff;
      tab_we = 1'b0;  tab_wa = clr_ff;  tab_wd = '0;  tab_ra = cur_ff;
      stk_we = 1'b0;  stk_wa = sc_ff[STK_AW-1:0];  stk_wd = '0;
      stk_ra = 12'(sc_ff - 13'd1);
      col_next = col_ff + 16'd1;
      row_step = '0;

      if (csr_valid) begin
         case (csr_index)
            REG_MIN_CODE_SIZE: begin
               mcs_in = csr_data[3:0];
               // A new code size reloads the width just as a clear code does.
               if (csr_data[3:0] < 4'd2) begin
                  ccw_in = 4'd3;  nfc_in = 13'd6;
               end else if (csr_data[3:0] > 4'd8) begin
                  ccw_in = 4'd9;  nfc_in = 13'd258;
               end else begin
                  ccw_in = csr_data[3:0] + 4'd1;
                  nfc_in = 13'(13'd1 << csr_data[3:0]) + 13'd2;
               end
            end
            REG_COLOR_BITS:    cbits_in  = csr_data[3:0];
            REG_IMAGE_WIDTH:   width_in  = csr_data;
            REG_IMAGE_HEIGHT:  height_in = csr_data;
            REG_INTERLACED:    ilace_in  = csr_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_CLR: begin
            tab_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_operation;
               byte_in = req_data_byte;
               phase_in = 1'b0;
               res_pix_in = '0;  res_x_in = '0;  res_y_in = '0;
               if (req_operation == OP_FEED && fin_ff) begin
                  res_st_in = ST_ENDED;
                  state_in = S_RSP;
               end else begin
                  state_in = S_DEC;
               end
            end
         end
         S_DEC: begin
            if (!fin_ff && sc_ff == '0 && bc_ff >= {1'b0, ccw_ff}) begin
               bb_in = bb_ff >> ccw_ff;
               bc_in = bc_ff - {1'b0, ccw_ff};
               if (code == {3'd0, clear_code} + 12'd1) begin
                  fin_in = 1'b1;
               end else if (code == {3'd0, clear_code}) begin
                  ccw_in = em + 4'd1;
                  nfc_in = {4'd0, clear_code} + 13'd2;
                  exp_in = 1'b1;
               end else if (exp_ff) begin
                  exp_in = 1'b0;
                  stk_we = 1'b1;
                  stk_wd = code[7:0] & cmask;
                  sc_in  = sc_ff + 13'd1;
                  lfc_in = code[7:0] & cmask;
                  prev_in = code;
               end else begin
                  incode_in = code;
                  // A code not yet in the table repeats the previous string plus its first pixel.
                  if ({1'b0, code} >= nfc_ff) begin
                     cur_in = prev_ff;
                     stk_we = 1'b1;
                     stk_wd = lfc_ff;
                     sc_in  = sc_ff + 13'd1;
                  end else begin
                     cur_in = code;
                  end
                  state_in = S_RD;
               end
            end else if (op_ff == OP_FEED) begin
               if (phase_ff) begin
                  res_st_in = ST_TAKEN;
                  state_in = S_RSP;
               end else if (sc_ff != '0) begin
                  res_st_in = ST_BUSY;
                  state_in = S_RSP;
               end else begin
                  bb_in = bb_ff | 24'({16'd0, byte_ff} << bc_ff);
                  bc_in = bc_ff + 5'd8;
                  phase_in = 1'b1;
               end
            end else if (sc_ff == '0) begin
               res_st_in = fin_ff ? ST_ENDED : ST_NEED;
               state_in = S_RSP;
            end else begin
               sc_in = sc_ff - 13'd1;
               state_in = S_POPD;
            end
         end
         S_RD: begin
            if (cur_ff > {4'd0, cmask} && sc_ff < 13'(STK_DEPTH - 1)) begin
               state_in = S_WR;
            end else begin
               stk_we = 1'b1;
               stk_wd = cur_ff[7:0] & cmask;
               sc_in  = sc_ff + 13'd1;
               lfc_in = cur_ff[7:0] & cmask;
               if (nfc_ff < 13'(TAB_DEPTH)) begin
                  tab_we = 1'b1;
                  tab_wa = nfc_ff[TAB_AW-1:0];
                  tab_wd = {prev_ff, cur_ff[7:0] & cmask};
                  nfc_in = nfc_next;
                  if (nfc_next >= 13'(13'd1 << ccw_ff) && ccw_ff < 4'(MAX_CODE_BITS))
                     ccw_in = ccw_ff + 4'd1;
               end
               prev_in = incode_ff;
               state_in = S_DEC;
            end
         end
         S_WR: begin
            stk_we = 1'b1;
            stk_wd = tab_rd_ff[7:0];
            sc_in  = sc_ff + 13'd1;
            cur_in = tab_rd_ff[19:8];
            state_in = S_RD;
         end
         S_POPD: begin
            res_st_in = ST_PIXEL;
            res_pix_in = stk_rd_ff;
            res_x_in = col_ff;
            res_y_in = row_ff;
            if (col_next != width_ff) begin
               col_in = col_next;
            end else begin
               col_in = '0;
               if (!ilace_ff) begin
                  row_in = row_ff + 16'd1;
               end else begin
                  case (pass_ff)
                     2'd0: begin
                        row_step = {1'b0, row_ff} + 17'd8;
                        if (row_step >= {1'b0, height_ff}) begin
                           pass_in = 2'd1;  row_step = 17'd4;
                        end
                     end
                     2'd1: begin
                        row_step = {1'b0, row_ff} + 17'd8;
                        if (row_step >= {1'b0, height_ff}) begin
                           pass_in = 2'd2;  row_step = 17'd2;
                        end
                     end
                     2'd2: begin
                        row_step = {1'b0, row_ff} + 17'd4;
                        if (row_step >= {1'b0, height_ff}) begin
                           pass_in = 2'd3;  row_step = 17'd1;
                        end
                     end
                     default: row_step = {1'b0, row_ff} + 17'd2;
                  endcase
                  row_in = row_step[15:0];
               end
            end
            state_in = S_RSP;
         end
         S_RSP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_st_in = res_st_ff;  rsp_pix_in = res_pix_ff;
               rsp_x_in = res_x_ff;  rsp_y_in = res_y_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (tab_we) tab_mem[tab_wa] <= tab_wd;
      tab_rd_ff <= tab_mem[tab_ra];
      if (stk_we) stk_mem[stk_wa] <= stk_wd;
      stk_rd_ff <= stk_mem[stk_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;  clr_ff <= '0;  op_ff <= OP_FEED;  phase_ff <= 1'b0;
         bb_ff <= '0;  bc_ff <= '0;  sc_ff <= '0;  ccw_ff <= 4'd9;  nfc_ff <= 13'd258;
         prev_ff <= '0;  lfc_ff <= '0;  exp_ff <= 1'b0;  fin_ff <= 1'b0;
         col_ff <= '0;  row_ff <= '0;  pass_ff <= '0;
         mcs_ff <= 4'd8;  cbits_ff <= 4'd8;  width_ff <= 16'd1;  height_ff <= 16'd1;
         ilace_ff <= 1'b0;  rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;  clr_ff <= clr_in;  op_ff <= op_in;  phase_ff <= phase_in;
         bb_ff <= bb_in;  bc_ff <= bc_in;  sc_ff <= sc_in;  ccw_ff <= ccw_in;
         nfc_ff <= nfc_in;  prev_ff <= prev_in;  lfc_ff <= lfc_in;  exp_ff <= exp_in;
         fin_ff <= fin_in;  col_ff <= col_in;  row_ff <= row_in;  pass_ff <= pass_in;
         mcs_ff <= mcs_in;  cbits_ff <= cbits_in;  width_ff <= width_in;
         height_ff <= height_in;  ilace_ff <= ilace_in;  rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;  cur_ff <= cur_in;  incode_ff <= incode_in;
      res_st_ff <= res_st_in;  res_pix_ff <= res_pix_in;
      res_x_ff <= res_x_in;  res_y_ff <= res_y_in;
      rsp_st_ff <= rsp_st_in;  rsp_pix_ff <= rsp_pix_in;
      rsp_x_ff <= rsp_x_in;  rsp_y_ff <= rsp_y_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_st_ff;
   assign rsp_pixel_index = rsp_pix_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
endmodule
`default_nettype wire

@@ tb/gif_lzw_pixel_decoder_unit_checker.sv @@
// Scoreboard for the GIF LZW pixel decoder: predicts every result beat and compares it.
module gif_lzw_pixel_decoder_unit_checker import gifd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic        req_operation,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [2:0]  rsp_status,
   input  wire logic [7:0]  rsp_pixel_index,
   input  wire logic [15:0] rsp_pixel_x,
   input  wire logic [15:0] rsp_pixel_y,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data,
   output int               fail_count,
   output int               pending_count,
   output int               held_bits
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  index;
      logic [15:0] x;
      logic [15:0] y;
   } pixel_beat_type;

   pixel_beat_type expected_beats[$];

   logic [3:0]  cfg_min_size, cfg_colour_bits;
   logic [15:0] cfg_width, cfg_height;
   logic        cfg_interlaced;

   logic [11:0] prefix_mem[TAB_DEPTH];
   logic [7:0]  suffix_mem[TAB_DEPTH];
   logic [7:0]  pixel_lifo[STK_DEPTH];
   logic [23:0] bit_acc;
   int unsigned bit_cnt, lifo_cnt, code_width, free_code, prev_code, first_char;
   logic        after_clear, ended, il_on;
   logic [15:0] col_pos, row_pos;
   int unsigned pass_no;

   function automatic int unsigned eff_min_size();
      if (cfg_min_size < 2) return 2;
      if (cfg_min_size > 8) return 8;
      return cfg_min_size;
   endfunction

   function automatic int unsigned literal_mask();
      int unsigned b;
      b = cfg_colour_bits;
      if (b < 1) b = 1;
      if (b > 8) b = 8;
      return (1 << b) - 1;
   endfunction

   function automatic void restart_width();
      code_width = eff_min_size() + 1;
      free_code  = (1 << eff_min_size()) + 2;
   endfunction

   function automatic void push_index(int unsigned v);
      if (lifo_cnt < STK_DEPTH) begin
         pixel_lifo[lifo_cnt] = v[7:0];
         lifo_cnt++;
      end
   endfunction

   function automatic void take_code(int unsigned code);
      int unsigned clr, msk, walk, fin;
      clr = 1 << eff_min_size();
      msk = literal_mask();
      if (code == clr + 1) begin
         ended = 1'b1;
         return;
      end
      if (code == clr) begin
         restart_width();
         after_clear = 1'b1;
         return;
      end
      if (after_clear) begin
         after_clear = 1'b0;
         first_char  = code & msk;
         push_index(first_char);
         prev_code = code & 12'hFFF;
         return;
      end
      walk = code;
      if (walk >= free_code) begin
         walk = prev_code;
         push_index(first_char);
      end
      while (walk > msk && lifo_cnt < STK_DEPTH - 1) begin
         if (walk < TAB_DEPTH) begin
            push_index(suffix_mem[walk]);
            walk = prefix_mem[walk];
         end else begin
            push_index(0);
            walk = 0;
         end
      end
      fin = walk & msk;
      first_char = fin;
      push_index(fin);
      if (free_code < TAB_DEPTH) begin
         prefix_mem[free_code] = prev_code[11:0];
         suffix_mem[free_code] = fin[7:0];
         free_code++;
         if (free_code >= (1 << code_width) && code_width < MAX_CODE_BITS) code_width++;
      end
      prev_code = code & 12'hFFF;
   endfunction

   function automatic void decode_ready_codes();
      int unsigned code;
      while (!ended && lifo_cnt == 0 && bit_cnt >= code_width) begin
         code = bit_acc & ((1 << code_width) - 1);
         bit_acc = bit_acc >> code_width;
         bit_cnt -= code_width;
         take_code(code);
      end
   endfunction

   function automatic void step_position();
      int unsigned nxt;
      col_pos = col_pos + 16'd1;
      if (col_pos != cfg_width) return;
      col_pos = '0;
      if (!il_on) begin
         row_pos = row_pos + 16'd1;
         return;
      end
      case (pass_no)
         0: begin
            nxt = row_pos + 8;
            if (nxt >= cfg_height) begin pass_no = 1; nxt = 4; end
         end
         1: begin
            nxt = row_pos + 8;
            if (nxt >= cfg_height) begin pass_no = 2; nxt = 2; end
         end
         2: begin
            nxt = row_pos + 4;
            if (nxt >= cfg_height) begin pass_no = 3; nxt = 1; end
         end
         default: nxt = row_pos + 2;
      endcase
      row_pos = nxt[15:0];
   endfunction

   function automatic pixel_beat_type predict_beat(logic op, logic [7:0] data);
      pixel_beat_type r;
      r = '0;
      if (op == OP_FEED) begin
         if (ended) begin
            r.status = ST_ENDED;
            return r;
         end
         decode_ready_codes();
         if (lifo_cnt != 0) begin
            r.status = ST_BUSY;
            return r;
         end
         bit_acc = bit_acc | (24'(data) << bit_cnt);
         bit_cnt += 8;
         decode_ready_codes();
         r.status = ST_TAKEN;
         return r;
      end
      if (lifo_cnt == 0) decode_ready_codes();
      if (lifo_cnt == 0) begin
         r.status = ended ? ST_ENDED : ST_NEED;
         return r;
      end
      lifo_cnt--;
      r.status = ST_PIXEL;
      r.index  = pixel_lifo[lifo_cnt];
      r.x      = col_pos;
      r.y      = row_pos;
      step_position();
      return r;
   endfunction

   function automatic void write_register(logic [2:0] idx, logic [15:0] val);
      case (idx)
         REG_MIN_CODE_SIZE: begin cfg_min_size = val[3:0]; restart_width(); end
         REG_COLOR_BITS:    cfg_colour_bits = val[3:0];
         REG_IMAGE_WIDTH:   cfg_width = val;
         REG_IMAGE_HEIGHT:  cfg_height = val;
         REG_INTERLACED:    il_on = val[0];
         default: ;
      endcase
   endfunction

   assign held_bits = bit_cnt;

   always @(posedge clock) begin
      pixel_beat_type want;
      if (reset) begin
         cfg_min_size = 4'd8;
         cfg_colour_bits = 4'd8;
         cfg_width = 16'd1;
         cfg_height = 16'd1;
         il_on = 1'b0;
         for (int i = 0; i < TAB_DEPTH; i++) begin
            prefix_mem[i] = '0;
            suffix_mem[i] = '0;
         end
         bit_acc = '0;
         bit_cnt = 0;
         lifo_cnt = 0;
         restart_width();
         prev_code = 0;
         first_char = 0;
         after_clear = 1'b0;
         ended = 1'b0;
         col_pos = '0;
         row_pos = '0;
         pass_no = 0;
         fail_count = 0;
         expected_beats.delete();
      end else begin
         if (csr_valid && csr_ready) write_register(csr_index, csr_data);
         if (req_valid && req_ready)
            expected_beats.push_back(predict_beat(req_operation, req_data_byte));
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               $error("result beat with no expectation waiting: status %0d", rsp_status);
               fail_count++;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_pixel_index !== want.index) begin
                  $error("pixel_index: expected %0d, actual %0d", want.index, rsp_pixel_index);
                  fail_count++;
               end
               if (rsp_pixel_x !== want.x) begin
                  $error("pixel_x: expected %0d, actual %0d", want.x, rsp_pixel_x);
                  fail_count++;
               end
               if (rsp_pixel_y !== want.y) begin
                  $error("pixel_y: expected %0d, actual %0d", want.y, rsp_pixel_y);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_beats.size();
   end
endmodule

@@ tb/gif_lzw_pixel_decoder_unit_tb.sv @@
// Testbench top for the GIF LZW pixel decoder: stimulus, clocking and the verdict.
module gif_lzw_pixel_decoder_unit_tb;
   import gifd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0, req_ready;
   logic        req_operation = OP_FEED;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid, rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_pixel_index;
   logic [15:0] rsp_pixel_x, rsp_pixel_y;
   logic        csr_valid = 1'b0, csr_ready;
   logic [2:0]  csr_index = REG_MIN_CODE_SIZE;
   logic [15:0] csr_data = '0;
   int          fail_count, pending_count, held_bits;
   logic        quiet = 1'b0;

   // Code stream generator state, kept in step with the decoder's own widths.
   logic [31:0] pack_acc;
   int unsigned pack_bits, gen_min, gen_width, gen_free, gen_mask;
   logic        gen_after_clear;

   always #5 clock = ~clock;

   gif_lzw_pixel_decoder_unit u_top (.*);

   gif_lzw_pixel_decoder_unit_checker u_chk (.*);

   always @(negedge clock) rsp_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 17);

   initial begin
      #20ms;
      $display("gif_lzw_pixel_decoder_unit verification failed");
      $finish;
   end

   task automatic run_beat(input logic op, input logic [7:0] data, output logic [2:0] st);
      while (!quiet && $urandom_range(99) < 17) @(negedge clock);
      req_valid = 1'b1;
      req_operation = op;
      req_data_byte = data;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      req_valid = 1'b0;
      while (!(rsp_valid && rsp_ready)) @(posedge clock);
      st = rsp_status;
      @(negedge clock);
   endtask

   task automatic drain_pixels();
      logic [2:0] st;
      do run_beat(OP_PULL, 8'($urandom), st); while (st == ST_PIXEL);
   endtask

   task automatic feed_byte(input logic [7:0] b);
      logic [2:0] st;
      if ($urandom_range(99) < 20) run_beat(OP_PULL, 8'($urandom), st);
      forever begin
         run_beat(OP_FEED, b, st);
         if (st != ST_BUSY) break;
         drain_pixels();
      end
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [15:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic put_code(input int unsigned code);
      pack_acc  = pack_acc | ((code & ((1 << gen_width) - 1)) << pack_bits);
      pack_bits = pack_bits + gen_width;
      while (pack_bits >= 8) begin
         feed_byte(pack_acc[7:0]);
         pack_acc  = pack_acc >> 8;
         pack_bits = pack_bits - 8;
      end
   endtask

   function automatic int unsigned saturate(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   // One image: reconfigure, clear, random codes, then a closing clear (or the end code).
   task automatic run_image(input int n_codes, input logic [3:0] min_reg, input logic [3:0] cb_reg,
                            input logic [15:0] w, input logic [15:0] h, input logic il,
                            input logic last);
      int unsigned clr, code, p, r;
      drain_pixels();
      repeat (16) @(negedge clock);
      r = held_bits;
      // The leftover bits are zero, so the opening clear must have at least that many low zeros.
      if (saturate(min_reg, 2, 8) < r) min_reg = 4'(r);
      write_csr(REG_MIN_CODE_SIZE, 16'(min_reg));
      write_csr(REG_COLOR_BITS, 16'(cb_reg));
      write_csr(REG_IMAGE_WIDTH, w);
      write_csr(REG_IMAGE_HEIGHT, h);
      write_csr(REG_INTERLACED, 16'(il));
      gen_min   = saturate(min_reg, 2, 8);
      gen_mask  = (1 << saturate(cb_reg, 1, 8)) - 1;
      clr       = 1 << gen_min;
      gen_width = gen_min + 1;
      gen_free  = clr + 2;
      pack_acc  = clr >> r;
      pack_bits = gen_width - r;
      gen_after_clear = 1'b1;
      for (int i = 0; i < n_codes; i++) begin
         p = $urandom_range(99);
         if (!gen_after_clear && p < 3) begin
            put_code(clr);
            gen_width = gen_min + 1;
            gen_free  = clr + 2;
            gen_after_clear = 1'b1;
            continue;
         end
         if (gen_after_clear) code = (p < 85) ? $urandom_range(gen_mask) : $urandom_range(clr - 1);
         else if (p < 8) code = gen_free;
         else if (p < 11) code = $urandom_range((1 << gen_width) - 1);
         else if (p < 60 || gen_free <= clr + 2) code = $urandom_range(gen_mask);
         else code = $urandom_range(gen_free - 1, clr + 2);
         if (code == clr || code == clr + 1) code = $urandom_range(gen_mask);
         put_code(code);
         if (gen_after_clear) gen_after_clear = 1'b0;
         else if (gen_free < TAB_DEPTH) begin
            gen_free++;
            if (gen_free >= (1 << gen_width) && gen_width < MAX_CODE_BITS) gen_width++;
         end
      end
      put_code(last ? clr + 1 : clr);
      if (pack_bits > 0) feed_byte(pack_acc[7:0]);
      pack_bits = 0;
      pack_acc  = '0;
      drain_pixels();
   endtask

   initial begin
      logic [2:0] st;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: out-of-range registers, need-bytes pull, codes with no leading clear.
      write_csr(REG_MIN_CODE_SIZE, 16'd15);
      write_csr(REG_COLOR_BITS, 16'd0);
      write_csr(REG_IMAGE_WIDTH, 16'hFFFF);
      write_csr(REG_IMAGE_HEIGHT, 16'hFFFF);
      write_csr(REG_INTERLACED, 16'd1);
      run_beat(OP_PULL, 8'hFF, st);
      run_beat(OP_FEED, 8'h00, st);
      run_beat(OP_FEED, 8'hFF, st);
      run_beat(OP_FEED, 8'hAA, st);
      run_beat(OP_FEED, 8'h55, st);
      drain_pixels();
      run_beat(OP_FEED, 8'h00, st);
      drain_pixels();
      write_csr(REG_COLOR_BITS, 16'd9);
      write_csr(REG_MIN_CODE_SIZE, 16'd0);
      run_beat(OP_FEED, 8'hFF, st);
      run_beat(OP_FEED, 8'h81, st);
      drain_pixels();
      write_csr(REG_MIN_CODE_SIZE, 16'd1);

      run_image(25, 4'd2, 4'd2, 16'd4, 16'd3, 1'b0, 1'b0);
      run_image(40, 4'd8, 4'd8, 16'd7, 16'd20, 1'b1, 1'b0);
      run_image(25, 4'd4, 4'd3, 16'd1, 16'd1, 1'b1, 1'b0);
      quiet = 1'b1;
      run_image(40, 4'd3, 4'd3, 16'd5, 16'd9, 1'b1, 1'b0);
      quiet = 1'b0;
      run_image(30, 4'd9, 4'd15, 16'hFFFF, 16'd2, 1'b0, 1'b0);
      // One-bit colour depth, so every table code above 1 walks a string chain of the table.
      run_image(50, 4'd2, 4'd1, 16'd13, 16'd11, 1'b1, 1'b0);
      for (int k = 0; k < 4; k++)
         run_image($urandom_range(10, 20), 4'($urandom_range(15)), 4'($urandom_range(15)),
                   16'($urandom_range(1, 9)), 16'($urandom_range(1, 30)), 1'($urandom),
                   1'b0);
      run_image(25, 4'd6, 4'd5, 16'd3, 16'hFFFF, 1'b0, 1'b1);
      run_beat(OP_FEED, 8'h12, st);
      run_beat(OP_FEED, 8'hED, st);
      run_beat(OP_PULL, 8'h00, st);

      while (pending_count != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (fail_count == 0)
         $display("gif_lzw_pixel_decoder_unit verification clean");
      else
         $display("gif_lzw_pixel_decoder_unit verification failed");
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/core/gifd_pkg.sv
rtl/core/gif_lzw_pixel_decoder_unit.sv
tb/gif_lzw_pixel_decoder_unit_checker.sv
tb/gif_lzw_pixel_decoder_unit_tb.sv
